@@ hdl/acfc_pkg.sv @@
// Shared types, constants and helper functions for the ASCII frame CRC-8 checker.
// Depends on nothing; every other file of the block uses it by scoped names.
`default_nettype none

package acfc_pkg;

    // Width of the parsed signed values and of the magnitude accumulator
    localparam int VALUE_BITS = 16;
    localparam int ACC_BITS   = VALUE_BITS + 1;
    localparam int PROD_BITS  = ACC_BITS + 4;

    // Magnitude limit 2^(VALUE_BITS-1) and the saturation value one above it
    localparam logic [ACC_BITS-1:0] VALUE_LIMIT = {2'b01, {(VALUE_BITS - 1){1'b0}}};
    localparam logic [ACC_BITS-1:0] VALUE_SAT   = VALUE_LIMIT + ACC_BITS'(1);

    // Token counter (saturating) and token positions in a line
    localparam int                  TOKEN_BITS      = 3;
    localparam logic [TOKEN_BITS-1:0] TOKEN_MAX       = 3'd7;
    localparam logic [TOKEN_BITS-1:0] TOK_HEADER      = 3'd1;
    localparam logic [TOKEN_BITS-1:0] TOK_FIRST_VALUE = 3'd2;
    localparam logic [TOKEN_BITS-1:0] TOK_LAST_VALUE  = 3'd4;
    localparam logic [TOKEN_BITS-1:0] TOK_CRC         = 3'd5;

    // Character codes
    localparam logic [7:0] CHAR_TAB     = 8'h09;
    localparam logic [7:0] CHAR_LF      = 8'h0A;
    localparam logic [7:0] CHAR_VT      = 8'h0B;
    localparam logic [7:0] CHAR_FF      = 8'h0C;
    localparam logic [7:0] CHAR_CR      = 8'h0D;
    localparam logic [7:0] CHAR_SP      = 8'h20;
    localparam logic [7:0] CHAR_PLUS    = 8'h2B;
    localparam logic [7:0] CHAR_MINUS   = 8'h2D;
    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_NINE    = 8'h39;
    localparam logic [7:0] CHAR_HEADER  = 8'h58;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;

    // CRC polynomial register reset (x^8 + x^2 + x + 1)
    localparam logic [7:0] POLY_RESET = 8'h07;

    // Queue between the classifier and the parser
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        CLS_TEXT,
        CLS_SEP,
        CLS_EOL
    } t_byte_class;

    typedef struct packed {
        t_byte_class cls;
        logic [7:0]  data;
    } t_cls_word;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FORMAT = 2'd1,
        ST_NUMBER = 2'd2,
        ST_CRC    = 2'd3
    } t_status;

    typedef struct packed {
        logic neg;
        logic digit;
        logic stop;
        logic ovf;
    } t_num_flags;

    // One byte of MSB-first CRC-8, init folded into crc, x^8 term implied
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc,
                                             input logic [7:0] data,
                                             input logic [7:0] poly);
        logic [7:0] r;
        r = crc ^ data;
        for (int k = 0; k < 8; k++) begin
            r = r[7] ? ((r << 1) ^ poly) : (r << 1);
        end
        return r;
    endfunction

    // Lower-case hex digit of a nibble
    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        return (nib < 4'd10) ? (CHAR_ZERO + {4'h0, nib})
                             : (CHAR_LOWER_A + ({4'h0, nib} - 8'd10));
    endfunction

endpackage

`default_nettype wire

@@ hdl/acfc_if.sv @@
// Valid/ready channel interfaces of the ASCII frame CRC-8 checker.
// Depends on acfc_pkg for the value width.
`default_nettype none

// Received byte channel
interface acfc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] line_byte;

    modport source (output valid, output line_byte, input ready);
    modport sink   (input valid, input line_byte, output ready);
endinterface

// Parsed frame result channel
interface acfc_result_if;
    logic                                   valid;
    logic                                   ready;
    logic [1:0]                             frame_status;
    logic signed [acfc_pkg::VALUE_BITS-1:0] acc_x;
    logic signed [acfc_pkg::VALUE_BITS-1:0] acc_y;
    logic signed [acfc_pkg::VALUE_BITS-1:0] fire_value;

    modport source (output valid, output frame_status, output acc_x, output acc_y,
                    output fire_value, input ready);
    modport sink   (input valid, input frame_status, input acc_x, input acc_y,
                    input fire_value, output ready);
endinterface

`default_nettype wire

@@ hdl/ascii_frame_crc8_checker.sv @@
// Top level of the ASCII frame CRC-8 checker: front end, word queue and parser back end.
// Depends on acfc_pkg, acfc_if, acfc_front, acfc_queue and acfc_back.
//
// Usage:
//   i_line carries one received byte per word (valid/ready). Bytes are split
//   into tokens at space, tab, CR, VT and FF; a line feed closes the line.
//   o_result carries one word per line: frame_status (0 ok, 1 header or token
//   count bad, 2 bad number, 3 CRC mismatch) and acc_x, acc_y, fire_value,
//   which are zero unless the status is ok.
//   i_cfg_wr_en/i_cfg_wr_data write the low eight bits of the CRC polynomial
//   (x^8 implied); write it only while no line is in flight.
//   Throughput: one byte per cycle while results are taken. The classifier feeds a two-word
//   queue and the parser pops one word per cycle; the CRC-8 advances one byte per cycle.
//   A line feed is written into the queue and, once popped, loads the result
//   register that presents its result word.
//   When the receiver stalls, the finished result holds in the output register;
//   text bytes keep flowing and only the next line feed waits, so i_line.ready
//   drops once the queue fills behind it.
//   Reset (synchronous, active low) empties the queue, clears the line state,
//   drops the result word and sets the polynomial to 0x07.
`default_nettype none

module ascii_frame_crc8_checker (
    input  logic          i_clk,
    input  logic          i_rst_n,
    acfc_in_if.sink       i_line,
    acfc_result_if.source o_result,
    input  logic          i_cfg_wr_en,
    input  logic [7:0]    i_cfg_wr_data
);

    logic                    push;
    logic                    pop;
    acfc_pkg::t_cls_word     push_word;
    acfc_pkg::t_cls_word     head_word;
    acfc_pkg::t_queue_status q_status;

    // Byte classifier
    acfc_front u_front (
        .i_line   (i_line),
        .i_status (q_status),
        .o_push   (push),
        .o_word   (push_word)
    );

    // Word queue
    acfc_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_word (push_word),
        .i_pop       (pop),
        .o_head_word (head_word),
        .o_status    (q_status)
    );

    // Parser, CRC and result register
    acfc_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_head_word   (head_word),
        .i_status      (q_status),
        .o_pop         (pop),
        .o_result      (o_result)
    );

endmodule

`default_nettype wire

@@ hdl/acfc_front.sv @@
// Front end: accepts received bytes and classifies them as text, separator or line end.
// Depends on acfc_pkg and acfc_in_if; feeds acfc_queue.
`default_nettype none

module acfc_front (
    acfc_in_if.sink                  i_line,
    input  acfc_pkg::t_queue_status  i_status,
    output logic                     o_push,
    output acfc_pkg::t_cls_word      o_word
);

    acfc_pkg::t_byte_class cls;

    // Take a word whenever the queue has room
    assign i_line.ready = !i_status.full;
    assign o_push       = i_line.valid && !i_status.full;

    // Byte class decode
    always_comb begin
        unique case (i_line.line_byte) inside
            acfc_pkg::CHAR_LF: cls = acfc_pkg::CLS_EOL;
            acfc_pkg::CHAR_SP, acfc_pkg::CHAR_TAB, acfc_pkg::CHAR_VT,
            acfc_pkg::CHAR_FF, acfc_pkg::CHAR_CR: cls = acfc_pkg::CLS_SEP;
            default: cls = acfc_pkg::CLS_TEXT;
        endcase
    end

    assign o_word.cls  = cls;
    assign o_word.data = i_line.line_byte;

endmodule

`default_nettype wire

@@ hdl/acfc_queue.sv @@
// Short FIFO of classified words between the front end and the parser.
// Depends on acfc_pkg for the word type and depth.
`default_nettype none

module acfc_queue (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_push,
    input  acfc_pkg::t_cls_word      i_push_word,
    input  logic                     i_pop,
    output acfc_pkg::t_cls_word      o_head_word,
    output acfc_pkg::t_queue_status  o_status
);

    acfc_pkg::t_cls_word                r_mem [acfc_pkg::QUEUE_DEPTH];
    logic [acfc_pkg::QPTR_BITS-1:0]     r_wr_ptr, n_wr_ptr;
    logic [acfc_pkg::QPTR_BITS-1:0]     r_rd_ptr, n_rd_ptr;
    logic [acfc_pkg::QCNT_BITS-1:0]     r_count,  n_count;

    localparam logic [acfc_pkg::QPTR_BITS-1:0] LAST_PTR =
        acfc_pkg::QPTR_BITS'(acfc_pkg::QUEUE_DEPTH - 1);
    localparam logic [acfc_pkg::QCNT_BITS-1:0] FULL_COUNT =
        acfc_pkg::QCNT_BITS'(acfc_pkg::QUEUE_DEPTH);

    // Pointer and fill count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_word;
        end
    end

    assign o_head_word    = r_mem[r_rd_ptr];
    assign o_status.full  = (r_count == FULL_COUNT);
    assign o_status.empty = (r_count == '0);

endmodule

`default_nettype wire

@@ hdl/acfc_back.sv @@
// Back end: tokenizes classified words, parses the values, runs the CRC-8 and
// holds the result word. Depends on acfc_pkg and acfc_result_if; fed by acfc_queue.
`default_nettype none

module acfc_back (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_wr_en,
    input  logic [7:0]               i_cfg_wr_data,
    input  acfc_pkg::t_cls_word      i_head_word,
    input  acfc_pkg::t_queue_status  i_status,
    output logic                     o_pop,
    acfc_result_if.source            o_result
);

    localparam int VB = acfc_pkg::VALUE_BITS;
    localparam int AB = acfc_pkg::ACC_BITS;
    localparam int PB = acfc_pkg::PROD_BITS;

    // Line state
    logic [acfc_pkg::TOKEN_BITS-1:0] r_tok_cnt, n_tok_cnt;
    logic                            r_inside,  n_inside;
    logic                            r_hdr,     n_hdr;
    logic [AB-1:0]                   r_acc,     n_acc;
    acfc_pkg::t_num_flags            r_flags,   n_flags;
    logic                            r_nbad,    n_nbad;
    logic [1:0]                      r_pos,     n_pos;
    logic                            r_match,   n_match;

    // CRC and held values
    logic [7:0]                      r_poly;
    logic [7:0]                      r_crc,     n_crc;
    logic                            r_crc_dup, n_crc_dup;
    logic [VB-1:0]                   r_held [3];

    // Result register
    logic                            r_out_valid;
    acfc_pkg::t_status               r_out_status;
    logic signed [VB-1:0]            r_out_x, r_out_y, r_out_f;

    logic                            slot_free;
    logic                            is_eol;
    logic                            eol_pop;
    logic [7:0]                      c;
    logic                            first;
    logic [acfc_pkg::TOKEN_BITS-1:0] tok_inc, cur_cnt;
    logic [AB-1:0]                   base_acc;
    acfc_pkg::t_num_flags            base_flags;
    logic                            is_digit;
    logic [7:0]                      digit_code;
    logic [PB-1:0]                   acc_wide, prod;
    logic                            prod_ovf;
    logic                            fin_value;
    logic                            fin_bad;
    logic [VB-1:0]                   fin_mag, fin_signed, fin_val;
    logic [1:0]                      hold_idx;
    logic                            len2;
    logic                            pos_over;
    logic [3:0]                      exp_nib;
    logic                            pos_ok;
    acfc_pkg::t_status               status;

    // Pop: line ends wait for a free result slot, everything else flows
    assign slot_free = !r_out_valid || o_result.ready;
    assign is_eol    = (i_head_word.cls == acfc_pkg::CLS_EOL);
    assign o_pop     = !i_status.empty && (!is_eol || slot_free);
    assign eol_pop   = o_pop && is_eol;

    // Token start and digit accumulate
    assign c          = i_head_word.data;
    assign first      = !r_inside;
    assign tok_inc    = (r_tok_cnt == acfc_pkg::TOKEN_MAX) ? r_tok_cnt : r_tok_cnt + 1'b1;
    assign cur_cnt    = first ? tok_inc : r_tok_cnt;
    assign base_acc   = first ? '0 : r_acc;
    assign base_flags = first ? '0 : r_flags;
    assign is_digit   = (c >= acfc_pkg::CHAR_ZERO) && (c <= acfc_pkg::CHAR_NINE);
    assign digit_code = c - acfc_pkg::CHAR_ZERO;
    assign acc_wide   = PB'(base_acc);
    assign prod       = (acc_wide << 3) + (acc_wide << 1) + PB'(digit_code[3:0]);
    assign prod_ovf   = prod > PB'(acfc_pkg::VALUE_LIMIT);

    // Value token end: range check and sign
    assign fin_value  = o_pop && (i_head_word.cls == acfc_pkg::CLS_SEP) && r_inside
                        && (r_tok_cnt >= acfc_pkg::TOK_FIRST_VALUE)
                        && (r_tok_cnt <= acfc_pkg::TOK_LAST_VALUE);
    assign fin_bad    = !r_flags.digit || r_flags.ovf || (r_acc > acfc_pkg::VALUE_LIMIT)
                        || (!r_flags.neg && (r_acc == acfc_pkg::VALUE_LIMIT));
    assign fin_mag    = r_acc[VB-1:0];
    assign fin_signed = r_flags.neg ? (VB'(0) - fin_mag) : fin_mag;
    assign fin_val    = fin_bad ? '0 : fin_signed;
    assign hold_idx   = r_tok_cnt[1:0] - 2'd2;

    // CRC text: one hex digit when the high nibble is zero, else two
    assign len2     = (r_crc[7:4] != 4'h0);
    assign pos_over = len2 ? (r_pos >= 2'd2) : (r_pos >= 2'd1);
    assign exp_nib  = (len2 && (r_pos == 2'd0)) ? r_crc[7:4] : r_crc[3:0];
    assign pos_ok   = (r_pos == (len2 ? 2'd2 : 2'd1));

    // Frame status at line end
    always_comb begin
        if ((r_tok_cnt < acfc_pkg::TOK_CRC) || !r_hdr) begin
            status = acfc_pkg::ST_FORMAT;
        end else if (r_nbad) begin
            status = acfc_pkg::ST_NUMBER;
        end else if (!r_match || !pos_ok) begin
            status = acfc_pkg::ST_CRC;
        end else begin
            status = acfc_pkg::ST_OK;
        end
    end

    // Tokenizer and parser next state
    always_comb begin
        n_tok_cnt = r_tok_cnt;
        n_inside  = r_inside;
        n_hdr     = r_hdr;
        n_acc     = r_acc;
        n_flags   = r_flags;
        n_nbad    = r_nbad;
        n_pos     = r_pos;
        n_match   = r_match;
        if (o_pop) begin
            unique case (i_head_word.cls)
                acfc_pkg::CLS_EOL: begin
                    n_tok_cnt = '0;
                    n_inside  = 1'b0;
                    n_hdr     = 1'b0;
                    n_acc     = '0;
                    n_flags   = '0;
                    n_nbad    = 1'b0;
                    n_pos     = '0;
                    n_match   = 1'b1;
                end
                acfc_pkg::CLS_SEP: begin
                    n_inside = 1'b0;
                    if (fin_value && fin_bad) begin
                        n_nbad = 1'b1;
                    end
                end
                acfc_pkg::CLS_TEXT: begin
                    n_inside  = 1'b1;
                    n_tok_cnt = cur_cnt;
                    n_acc     = base_acc;
                    n_flags   = base_flags;
                    if (cur_cnt == acfc_pkg::TOK_HEADER) begin
                        n_hdr = first && (c == acfc_pkg::CHAR_HEADER);
                    end else if ((cur_cnt >= acfc_pkg::TOK_FIRST_VALUE)
                                 && (cur_cnt <= acfc_pkg::TOK_LAST_VALUE)) begin
                        if (!base_flags.stop) begin
                            if (first && ((c == acfc_pkg::CHAR_PLUS)
                                          || (c == acfc_pkg::CHAR_MINUS))) begin
                                n_flags.neg = (c == acfc_pkg::CHAR_MINUS);
                            end else if (is_digit) begin
                                n_flags.digit = 1'b1;
                                if (prod_ovf) begin
                                    n_acc       = acfc_pkg::VALUE_SAT;
                                    n_flags.ovf = 1'b1;
                                end else begin
                                    n_acc = prod[AB-1:0];
                                end
                            end else begin
                                n_flags.stop = 1'b1;
                            end
                        end
                    end else if (cur_cnt == acfc_pkg::TOK_CRC) begin
                        if (pos_over || (c != acfc_pkg::hex_char(exp_nib))) begin
                            n_match = 1'b0;
                        end
                        if (r_pos != 2'd3) begin
                            n_pos = r_pos + 2'd1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // CRC over b0,b0,b1,b2: first value loads and repeats on the next cycle
    always_comb begin
        n_crc     = r_crc;
        n_crc_dup = 1'b0;
        if (fin_value) begin
            n_crc     = acfc_pkg::crc8_byte(
                            (r_tok_cnt == acfc_pkg::TOK_FIRST_VALUE) ? 8'h00 : r_crc,
                            fin_val[7:0], r_poly);
            n_crc_dup = (r_tok_cnt == acfc_pkg::TOK_FIRST_VALUE);
        end else if (r_crc_dup) begin
            n_crc = acfc_pkg::crc8_byte(r_crc, r_held[0][7:0], r_poly);
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok_cnt   <= '0;
            r_inside    <= 1'b0;
            r_hdr       <= 1'b0;
            r_flags     <= '0;
            r_nbad      <= 1'b0;
            r_pos       <= '0;
            r_match     <= 1'b1;
            r_crc_dup   <= 1'b0;
            r_out_valid <= 1'b0;
            r_poly      <= acfc_pkg::POLY_RESET;
        end else begin
            r_tok_cnt <= n_tok_cnt;
            r_inside  <= n_inside;
            r_hdr     <= n_hdr;
            r_flags   <= n_flags;
            r_nbad    <= n_nbad;
            r_pos     <= n_pos;
            r_match   <= n_match;
            r_crc_dup <= n_crc_dup;
            if (eol_pop) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_wr_en) begin
                r_poly <= i_cfg_wr_data;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
        r_crc <= n_crc;
        if (fin_value) begin
            r_held[hold_idx] <= fin_val;
        end
        if (eol_pop) begin
            r_out_status <= status;
            r_out_x <= (status == acfc_pkg::ST_OK) ? $signed(r_held[0]) : '0;
            r_out_y <= (status == acfc_pkg::ST_OK) ? $signed(r_held[1]) : '0;
            r_out_f <= (status == acfc_pkg::ST_OK) ? $signed(r_held[2]) : '0;
        end
    end

    assign o_result.valid        = r_out_valid;
    assign o_result.frame_status = r_out_status;
    assign o_result.acc_x        = r_out_x;
    assign o_result.acc_y        = r_out_y;
    assign o_result.fire_value   = r_out_f;

    // A line end always leaves a result word behind
    a_eol_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        eol_pop |=> r_out_valid)
        else $error("line end popped without a result word");

    // Rejected frames carry zero values
    a_zero_on_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_status != acfc_pkg::ST_OK))
            |-> (r_out_x == '0) && (r_out_y == '0) && (r_out_f == '0))
        else $error("rejected frame carries nonzero values");

    // The repeated first CRC byte never collides with a value token end
    a_dup_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_crc_dup |-> !fin_value)
        else $error("CRC repeat step collides with value token end");

    // Line state is cleared after a line end
    a_line_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        eol_pop |=> (r_tok_cnt == '0) && !r_inside && r_match && !r_nbad)
        else $error("line state not cleared after line end");

endmodule

`default_nettype wire

@@ bench/tb_ascii_frame_crc8_checker.sv @@
// Testbench for ascii_frame_crc8_checker: drives text lines byte by byte and checks each frame
// result against a line parser and CRC-8 predictor kept in a small scoreboard class.
// Depends on acfc_pkg, acfc_if and the checker RTL.

module tb_ascii_frame_crc8_checker;
    timeunit 1ns;
    timeprecision 1ps;

    import acfc_pkg::*;

    localparam int SETTLE_CYCLES = 10;     // idle time before a polynomial write
    localparam int DRAIN_CYCLES  = 20;     // quiet time at the end of the run
    localparam int HOLD_CYCLES   = 300;    // one long receiver hold-off
    localparam int STALL_LIMIT   = 2000;   // cycles without any handshake
    localparam int PHASE_BYTES   = 130;

    typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_PERIODIC} t_rx_mode;

    typedef struct {
        t_status                status;
        logic [VALUE_BITS-1:0] x;
        logic [VALUE_BITS-1:0] y;
        logic [VALUE_BITS-1:0] f;
    } t_frame;

    // Line parser and CRC-8 predictor plus the frames still owed by the block
    class t_frame_tracker;
        logic [7:0]            poly;
        logic [2:0]            tok_cnt;
        bit                    in_tok;
        bit                    hdr_ok;
        bit                    num_bad;
        bit                    crc_match;
        int unsigned           mag;
        t_num_flags            nf;
        logic [VALUE_BITS-1:0] held [3];
        logic [7:0]            crc;
        logic [1:0]            crc_pos;
        t_frame                frames_due[$];
        int                    errors;
        int                    frames;
        int                    status_seen [4];

        function new();
            poly = POLY_RESET;
            crc = '0;
            foreach (held[i]) held[i] = '0;
            foreach (status_seen[i]) status_seen[i] = 0;
            errors = 0;
            frames = 0;
            clear_line();
        endfunction

        function void clear_line();
            tok_cnt = '0;
            in_tok = 0;
            hdr_ok = 0;
            mag = 0;
            nf = '0;
            crc_pos = '0;
            crc_match = 1;
            num_bad = 0;
        endfunction

        // Augmented MSB-first CRC over b0,b0,b1,b2 followed by eight zero bits
        function logic [7:0] crc_of(input logic [7:0] b0, input logic [7:0] b1,
                                    input logic [7:0] b2);
            logic [39:0] msg;
            logic [7:0]  r;
            bit          top;
            msg = {b0, b0, b1, b2, 8'h00};
            r = '0;
            for (int i = 39; i >= 0; i--) begin
                top = r[7];
                r = {r[6:0], msg[i]};
                if (top) r = r ^ poly;
            end
            return r;
        endfunction

        function void close_token();
            int unsigned           lim;
            bit                    bad;
            logic [VALUE_BITS-1:0] v;
            lim = 1 << (VALUE_BITS - 1);
            if (tok_cnt >= TOK_FIRST_VALUE && tok_cnt <= TOK_LAST_VALUE) begin
                bad = !nf.digit || nf.ovf || mag > lim || (!nf.neg && mag == lim);
                v = mag[VALUE_BITS-1:0];
                if (nf.neg) v = -v;
                if (bad) begin
                    num_bad = 1;
                    v = '0;
                end
                held[tok_cnt - TOK_FIRST_VALUE] = v;
                if (tok_cnt == TOK_LAST_VALUE)
                    crc = crc_of(held[0][7:0], held[1][7:0], held[2][7:0]);
            end
            in_tok = 0;
        endfunction

        function void number_byte(input logic [7:0] c, input bit first);
            int unsigned lim;
            lim = 1 << (VALUE_BITS - 1);
            if (nf.stop) return;
            if (first && (c == CHAR_PLUS || c == CHAR_MINUS)) begin
                if (c == CHAR_MINUS) nf.neg = 1;
                return;
            end
            if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
                nf.digit = 1;
                mag = mag * 10 + (c - CHAR_ZERO);
                if (mag > lim) begin
                    mag = lim + 1;
                    nf.ovf = 1;
                end
            end else begin
                nf.stop = 1;
            end
        endfunction

        // CRC text must be lower-case hex, no leading zero, nothing extra
        function void crc_text_byte(input logic [7:0] c);
            string      digits;
            logic [7:0] want;
            bit         two;
            digits = "0123456789abcdef";
            two = crc[7:4] != 4'h0;
            if (crc_pos >= (two ? 2'd2 : 2'd1)) begin
                crc_match = 0;
            end else begin
                want = digits[(two && crc_pos == 2'd0) ? crc[7:4] : crc[3:0]];
                if (c != want) crc_match = 0;
            end
            if (crc_pos < 2'd3) crc_pos++;
        endfunction

        function void take_byte(input logic [7:0] c);
            t_frame fr;
            bit     first;
            if (c == CHAR_LF) begin
                if (in_tok) close_token();
                if (tok_cnt < TOK_CRC || !hdr_ok) fr.status = ST_FORMAT;
                else if (num_bad) fr.status = ST_NUMBER;
                else if (!crc_match || crc_pos != ((crc[7:4] != 4'h0) ? 2'd2 : 2'd1))
                    fr.status = ST_CRC;
                else fr.status = ST_OK;
                fr.x = (fr.status == ST_OK) ? held[0] : '0;
                fr.y = (fr.status == ST_OK) ? held[1] : '0;
                fr.f = (fr.status == ST_OK) ? held[2] : '0;
                frames_due.push_back(fr);
                clear_line();
                return;
            end
            if (c == CHAR_SP || c == CHAR_TAB || c == CHAR_CR || c == CHAR_VT || c == CHAR_FF)
                begin
                if (in_tok) close_token();
                return;
            end
            first = !in_tok;
            if (first) begin
                in_tok = 1;
                if (tok_cnt < TOKEN_MAX) tok_cnt++;
                mag = 0;
                nf = '0;
            end
            if (tok_cnt == TOK_HEADER) hdr_ok = first && c == CHAR_HEADER;
            else if (tok_cnt >= TOK_FIRST_VALUE && tok_cnt <= TOK_LAST_VALUE)
                number_byte(c, first);
            else if (tok_cnt == TOK_CRC) crc_text_byte(c);
        endfunction

        function void compare(input string what, input logic [VALUE_BITS-1:0] want,
                              input logic [VALUE_BITS-1:0] got);
            if (got !== want) begin
                errors++;
                $display("%0t ns: %s mismatch, expected %0d actual %0d",
                         $time, what, $signed(want), $signed(got));
            end
        endfunction

        function void check_frame(input logic [1:0] st, input logic [VALUE_BITS-1:0] x,
                                  input logic [VALUE_BITS-1:0] y,
                                  input logic [VALUE_BITS-1:0] f);
            t_frame fr;
            if (frames_due.size() == 0) begin
                errors++;
                $display("%0t ns: result word with no line pending, status %0d", $time, st);
                return;
            end
            fr = frames_due.pop_front();
            frames++;
            status_seen[fr.status]++;
            compare("frame_status", VALUE_BITS'(fr.status), VALUE_BITS'(st));
            compare("acc_x", fr.x, x);
            compare("acc_y", fr.y, y);
            compare("fire_value", fr.f, f);
        endfunction
    endclass

    logic       i_clk;
    logic       i_rst_n;
    logic       cfg_wr_en;
    logic [7:0] cfg_wr_data;

    acfc_in_if     line_if();
    acfc_result_if res_if();

    t_frame_tracker board;
    int           burst_left = 0;
    int           bytes_sent = 0;
    int           bytes_taken = 0;
    int           idle_cycles = 0;
    int           stall_span = 0;
    int           rx_tick = 0;
    t_rx_mode     rx_mode = RX_OPEN;
    bit           hold_off = 0;

    ascii_frame_crc8_checker dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_line        (line_if),
        .o_result      (res_if),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Handshake monitor and no-progress watchdog
    always @(posedge i_clk) begin
        bit moved;
        if (i_rst_n) begin
            moved = 0;
            if (line_if.valid && line_if.ready) begin
                board.take_byte(line_if.line_byte);
                bytes_taken++;
                moved = 1;
            end
            if (res_if.valid && res_if.ready) begin
                board.check_frame(res_if.frame_status, res_if.acc_x, res_if.acc_y,
                                  res_if.fire_value);
                moved = 1;
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("%0t ns: no word moved for %0d cycles", $time, STALL_LIMIT);
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    // Result ready: rotating stall patterns, plus one long hold-off on request
    initial begin
        res_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off) begin
                res_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_off = 0;
            end else begin
                if (stall_span == 0) begin
                    rx_mode = t_rx_mode'($urandom_range(0, 3));
                    stall_span = $urandom_range(20, 120);
                end
                stall_span--;
                rx_tick++;
                case (rx_mode)
                    RX_OPEN:   res_if.ready <= 1'b1;
                    RX_COIN:   res_if.ready <= 1'($urandom_range(0, 1));
                    RX_SPARSE: res_if.ready <= ($urandom_range(0, 3) == 0);
                    default:   res_if.ready <= (rx_tick % 5 != 0);
                endcase
            end
        end
    end

    // One byte per call; the sender idles between bursts of random length
    task automatic send_byte(input logic [7:0] b);
        if (burst_left == 0) begin
            line_if.valid <= 1'b0;
            repeat (($urandom_range(0, 3) == 0) ? $urandom_range(5, 20) : $urandom_range(1, 2))
                @(posedge i_clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 12);
        end
        line_if.valid <= 1'b1;
        line_if.line_byte <= b;
        @(posedge i_clk);
        while (!line_if.ready) @(posedge i_clk);
        burst_left--;
        bytes_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i]);
    endtask

    function automatic string sep_run();
        string s;
        s = "";
        repeat (($urandom_range(0, 4) == 0) ? $urandom_range(2, 3) : 1) begin
            s = {s, " "};
            case ($urandom_range(0, 9))
                0:       s.putc(s.len() - 1, CHAR_TAB);
                1:       s.putc(s.len() - 1, CHAR_CR);
                2:       s.putc(s.len() - 1, CHAR_VT);
                3:       s.putc(s.len() - 1, CHAR_FF);
                default: s.putc(s.len() - 1, CHAR_SP);
            endcase
        end
        return s;
    endfunction

    // Value token text; val is what a clean parse gives (zero for a bad token)
    task automatic make_value(output string txt, output int val);
        int    pick;
        string digits;
        pick = $urandom_range(0, 99);
        if (pick >= 92) begin
            val = 0;
            case ($urandom_range(0, 7))
                0:       txt = "-";
                1:       txt = "+";
                2:       txt = "q5";
                3:       txt = "32768";
                4:       txt = "-32769";
                5:       txt = "123456789";
                6:       txt = "+-4";
                default: txt = "--";
            endcase
            return;
        end
        if (pick < 10) begin
            case ($urandom_range(0, 4))
                0:       val = 32767;
                1:       val = -32768;
                2:       val = 0;
                3:       val = -1;
                default: val = 1;
            endcase
        end else if (pick < 55) begin
            val = int'($urandom_range(0, 65535)) - 32768;
        end else begin
            val = int'($urandom_range(0, 400)) - 200;
        end
        digits = $sformatf("%0d", (val < 0) ? -val : val);
        if ($urandom_range(0, 9) == 0) digits = {"00", digits};
        if (val < 0) txt = {"-", digits};
        else if ($urandom_range(0, 4) == 0) txt = {"+", digits};
        else txt = digits;
        // trailing junk after the digits is dropped by the parser
        if ($urandom_range(0, 7) == 0) begin
            case ($urandom_range(0, 3))
                0:       txt = {txt, "a"};
                1:       txt = {txt, ".5"};
                2:       txt = {txt, "-7"};
                default: txt = {txt, "+kX"};
            endcase
        end
    endtask

    // Mostly well-formed frames with random content; some noise and broken frames
    task automatic send_random_line();
        int         pick;
        int         keep;
        int         val [3];
        string      toks[$];
        string      txt;
        string      line;
        logic [7:0] sum;
        pick = $urandom_range(0, 99);
        if (pick < 7) begin
            repeat ($urandom_range(0, 14)) send_byte(8'($urandom_range(0, 255)));
            send_byte(CHAR_LF);
            return;
        end
        case ($urandom_range(0, 19))
            0:       txt = "x";
            1:       txt = "XX";
            2:       txt = "Y";
            3:       txt = "X7";
            default: txt = "X";
        endcase
        toks.push_back(txt);
        for (int i = 0; i < 3; i++) begin
            make_value(txt, val[i]);
            toks.push_back(txt);
        end
        sum = board.crc_of(8'(val[0]), 8'(val[1]), 8'(val[2]));
        txt = $sformatf("%0h", sum);
        case ($urandom_range(0, 19))
            0:       txt = txt.toupper();
            1:       txt = {"0", txt};
            2:       txt = {txt, "0"};
            3:       txt = $sformatf("%0h", sum ^ 8'(1 << $urandom_range(0, 7)));
            4:       txt = txt.substr(0, 0);
            default: ;
        endcase
        toks.push_back(txt);
        if (pick < 12) begin
            keep = $urandom_range(0, 4);
            while (toks.size() > keep) void'(toks.pop_back());
        end
        if ($urandom_range(0, 12) == 0) begin
            toks.push_back("7");
            if ($urandom_range(0, 1) == 1) toks.push_back("zz");
        end
        line = ($urandom_range(0, 7) == 0) ? sep_run() : "";
        foreach (toks[i]) begin
            line = {line, toks[i]};
            if (i < toks.size() - 1) line = {line, sep_run()};
        end
        if ($urandom_range(0, 5) == 0) line = {line, sep_run()};
        line = {line, "\n"};
        send_text(line);
    endtask

    task automatic send_lines(input int n_bytes);
        int start;
        start = bytes_sent;
        while (bytes_sent - start < n_bytes) send_random_line();
    endtask

    // Polynomial write once the block has returned every frame and gone quiet
    task automatic write_poly(input logic [7:0] p);
        line_if.valid <= 1'b0;
        repeat (2) @(posedge i_clk);
        while (board.frames_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= p;
        @(posedge i_clk);
        cfg_wr_en <= 1'b0;
        board.poly = p;
        burst_left = 0;
    endtask

    initial begin
        logic [7:0] poly_plan [5];
        board = new();
        line_if.valid <= 1'b0;
        line_if.line_byte <= '0;
        cfg_wr_en <= 1'b0;
        cfg_wr_data <= '0;
        i_rst_n <= 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty line, extremes with mixed separators and an extra token, header failure
        send_text("\n");
        send_text($sformatf("X\t32767 -32768\r+0 %0h 9\n", board.crc_of(8'hFF, 8'h00, 8'h00)));
        send_text("Y - 1 2 0\n");
        send_lines(PHASE_BYTES - 33);

        poly_plan = '{8'h00, 8'hFF, 8'h9B, 8'($urandom_range(0, 255)), 8'h07};
        foreach (poly_plan[i]) begin
            write_poly(poly_plan[i]);
            if (i == 1) hold_off = 1;
            send_lines(PHASE_BYTES);
        end

        line_if.valid <= 1'b0;
        @(posedge i_clk);
        while (board.frames_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d bytes over six polynomial settings, %0d frames checked",
                 bytes_taken, board.frames);
        $display("Frame status mix: %0d ok, %0d format, %0d number, %0d crc",
                 board.status_seen[ST_OK], board.status_seen[ST_FORMAT],
                 board.status_seen[ST_NUMBER], board.status_seen[ST_CRC]);
        if (board.errors == 0 && board.frames_due.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
